FILE: rtl/tsc_pkg.sv
// Shared types and constants for the text statistics counter.
package tsc_pkg;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int BIN_AW  = 7;
    localparam int OUT_W   = 32;

    // Character classes
    localparam logic [BYTE_W-1:0] CH_NUL      = 8'd0;
    localparam logic [BYTE_W-1:0] CH_LF       = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'd13;
    localparam logic [BYTE_W-1:0] FIRST_PRINT = 8'd33;
    localparam logic [BYTE_W-1:0] LAST_PRINT  = 8'd126;
    localparam logic [BYTE_W-1:0] FIRST_HIGH  = 8'd128;

    // Histogram depth, one bin per printable character
    localparam int                BIN_COUNT = 94;
    localparam logic [BIN_AW-1:0] BIN_LAST  = 7'd93;

    typedef enum logic [OP_W-1:0] {
        OP_DATA   = 2'd0,
        OP_FINISH = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    localparam logic KIND_TOTALS = 1'b0;
    localparam logic KIND_BIN    = 1'b1;

    // Histogram control from the pipeline
    typedef struct packed {
        logic              rd;       // word accepted, look up its bin
        logic [BIN_AW-1:0] rd_addr;
        logic              inc;      // bump the bin held in stage 1
        logic              clr;      // drop every bin back to zero
    } t_hist_ctl;

endpackage

FILE: rtl/tsc_hist.sv
// Character histogram: bin memory with valid bits and a read-modify-write bypass.
module tsc_hist #(
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tsc_pkg::t_hist_ctl    i_ctl,
    output logic [COUNT_BITS-1:0] o_count
);

    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic [COUNT_BITS-1:0]      mem [tsc_pkg::BIN_COUNT];
    logic [tsc_pkg::BIN_COUNT-1:0] r_vld;
    logic [tsc_pkg::BIN_COUNT-1:0] n_vld;
    logic [COUNT_BITS-1:0]      r_rd_data;
    logic [tsc_pkg::BIN_AW-1:0] r_addr;
    logic                       r_byp_hit;
    logic [COUNT_BITS-1:0]      r_byp_data;
    logic [COUNT_BITS-1:0]      n_val;

    // Bin value as seen by the word in stage 1; the write of the word
    // ahead of it landed on the same edge as this read, hence the bypass
    always_comb begin
        if (r_byp_hit) begin
            o_count = r_byp_data;
        end else if (r_vld[r_addr]) begin
            o_count = r_rd_data;
        end else begin
            o_count = '0;
        end
        n_val = (o_count == '1) ? o_count : o_count + CNT_ONE;
    end

    always_comb begin
        n_vld = r_vld;
        if (i_ctl.clr) begin
            n_vld = '0;
        end else if (i_ctl.inc) begin
            n_vld[r_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.inc) begin
            mem[r_addr] <= n_val;
        end
        if (i_ctl.rd) begin
            r_rd_data  <= mem[i_ctl.rd_addr];
            r_addr     <= i_ctl.rd_addr;
            r_byp_data <= n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_byp_hit <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_ctl.rd) begin
                r_byp_hit <= i_ctl.inc && (r_addr == i_ctl.rd_addr);
            end
        end
    end

endmodule

FILE: rtl/tsc_counters.sv
// Line, word, byte and line length counters with end-of-text tracking.
module tsc_counters #(
    parameter int COUNT_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_retire,
    input  tsc_pkg::t_op               i_op,
    input  logic [tsc_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_hist_inc,
    output logic [COUNT_BITS-1:0]      o_lines,
    output logic [COUNT_BITS-1:0]      o_words,
    output logic [COUNT_BITS-1:0]      o_bytes,
    output logic [COUNT_BITS-1:0]      o_longest
);

    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic [COUNT_BITS-1:0] r_lines,  n_lines;
    logic [COUNT_BITS-1:0] r_words,  n_words;
    logic [COUNT_BITS-1:0] r_bytes,  n_bytes;
    logic [COUNT_BITS-1:0] r_cur,    n_cur;
    logic [COUNT_BITS-1:0] r_max,    n_max;
    logic                  r_prev_sep, n_prev_sep;
    logic                  r_ended,    n_ended;
    logic                  printable;
    logic                  separator;

    assign printable = (i_byte >= tsc_pkg::FIRST_PRINT) && (i_byte <= tsc_pkg::LAST_PRINT);
    assign separator = (i_byte < tsc_pkg::FIRST_PRINT) || (i_byte >= tsc_pkg::FIRST_HIGH);

    always_comb begin
        n_lines    = r_lines;
        n_words    = r_words;
        n_bytes    = r_bytes;
        n_cur      = r_cur;
        n_max      = r_max;
        n_prev_sep = r_prev_sep;
        n_ended    = r_ended;
        o_hist_inc = 1'b0;
        if (i_retire) begin
            case (i_op)
                tsc_pkg::OP_DATA: begin
                    if (!r_ended) begin
                        if (i_byte == tsc_pkg::CH_NUL) begin
                            n_ended = 1'b1;
                        end else begin
                            n_bytes = (r_bytes == '1) ? r_bytes : r_bytes + CNT_ONE;
                            if (i_byte == tsc_pkg::CH_LF) begin
                                n_lines = (r_lines == '1) ? r_lines : r_lines + CNT_ONE;
                                if (r_cur > r_max) begin
                                    n_max = r_cur;
                                end
                                n_cur = '0;
                            end else if (i_byte != tsc_pkg::CH_CR) begin
                                n_cur = (r_cur == '1) ? r_cur : r_cur + CNT_ONE;
                            end
                            if (printable) begin
                                o_hist_inc = 1'b1;
                                if (r_prev_sep && (r_words != '1)) begin
                                    n_words = r_words + CNT_ONE;
                                end
                            end
                            n_prev_sep = separator;
                        end
                    end
                end
                tsc_pkg::OP_CLEAR: begin
                    n_lines    = '0;
                    n_words    = '0;
                    n_bytes    = '0;
                    n_cur      = '0;
                    n_max      = '0;
                    n_prev_sep = 1'b1;
                    n_ended    = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines    <= '0;
            r_words    <= '0;
            r_bytes    <= '0;
            r_cur      <= '0;
            r_max      <= '0;
            r_prev_sep <= 1'b1;
            r_ended    <= 1'b0;
        end else begin
            r_lines    <= n_lines;
            r_words    <= n_words;
            r_bytes    <= n_bytes;
            r_cur      <= n_cur;
            r_max      <= n_max;
            r_prev_sep <= n_prev_sep;
            r_ended    <= n_ended;
        end
    end

    assign o_lines   = r_lines;
    assign o_words   = r_words;
    assign o_bytes   = r_bytes;
    assign o_longest = (r_cur > r_max) ? r_cur : r_max;

endmodule

FILE: rtl/text_statistics_counter.sv
// Text statistics counter top level: input stage, counters, histogram, result register.
//
// Takes one word per clock while o_stall is low: a text byte, a finish (totals
// report), a histogram bin read or a clear. A report is registered in stage 1,
// then in the output register that drives o_valid. A report held
// back by i_stall waits in stage 1 and stalls the input until the output drains.
// The word is registered into
// stage 1 while the histogram memory is read; in stage 1 the counters update and
// the bin is incremented and written back, with the prior word's write forwarded
// on a same-bin hit, and a report goes to the output register. The histogram has
// per-bin valid bits, so reset and clear take effect at once with no sweep.
// Counters are COUNT_BITS wide and saturate; reports carry their low 32 bits.
module text_statistics_counter #(
    parameter int COUNT_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [tsc_pkg::OP_W-1:0]    i_op,
    input  logic [tsc_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic [tsc_pkg::BIN_AW-1:0]  i_bin_index,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_kind,
    output logic [tsc_pkg::OUT_W-1:0]   o_line_count,
    output logic [tsc_pkg::OUT_W-1:0]   o_word_count,
    output logic [tsc_pkg::OUT_W-1:0]   o_byte_count,
    output logic [tsc_pkg::OUT_W-1:0]   o_longest_line,
    output logic [tsc_pkg::OUT_W-1:0]   o_bin_count
);

    localparam int EXT_W = tsc_pkg::OUT_W + COUNT_BITS;

    // stage 1
    logic                        r_s1_valid;
    tsc_pkg::t_op                r_s1_op;
    logic [tsc_pkg::BYTE_W-1:0]  r_s1_byte;
    logic                        r_s1_bin_ok;

    // output register
    logic                        r_out_valid;
    logic                        r_out_kind;
    logic [tsc_pkg::OUT_W-1:0]   r_out_lines;
    logic [tsc_pkg::OUT_W-1:0]   r_out_words;
    logic [tsc_pkg::OUT_W-1:0]   r_out_bytes;
    logic [tsc_pkg::OUT_W-1:0]   r_out_longest;
    logic [tsc_pkg::OUT_W-1:0]   r_out_bin;

    tsc_pkg::t_op                in_op;
    logic                        in_accept;
    logic                        in_bin_ok;
    logic [tsc_pkg::BIN_AW-1:0]  in_addr;
    logic [tsc_pkg::BYTE_W-1:0]  byte_off;
    logic                        s1_report;
    logic                        s1_retire;
    logic                        out_load;
    logic                        hist_inc;
    tsc_pkg::t_hist_ctl          hist_ctl;

    logic [COUNT_BITS-1:0]       cnt_lines;
    logic [COUNT_BITS-1:0]       cnt_words;
    logic [COUNT_BITS-1:0]       cnt_bytes;
    logic [COUNT_BITS-1:0]       cnt_longest;
    logic [COUNT_BITS-1:0]       bin_value;

    logic [EXT_W-1:0]            ext_lines;
    logic [EXT_W-1:0]            ext_words;
    logic [EXT_W-1:0]            ext_bytes;
    logic [EXT_W-1:0]            ext_longest;
    logic [EXT_W-1:0]            ext_bin;

    assign in_op = tsc_pkg::t_op'(i_op);

    // Stage 1 moves on unless it holds a report and the output is blocked
    assign s1_report = (r_s1_op == tsc_pkg::OP_FINISH) || (r_s1_op == tsc_pkg::OP_READ);
    assign s1_retire = r_s1_valid && (!s1_report || !r_out_valid || !i_stall);
    assign out_load  = s1_retire && s1_report;
    assign o_stall   = r_s1_valid && !s1_retire;
    assign in_accept = i_valid && !o_stall;

    // Bin address for the lookup; out of range and non-printable map to bin 0
    assign byte_off  = i_data_byte - tsc_pkg::FIRST_PRINT;
    assign in_bin_ok = (i_bin_index <= tsc_pkg::BIN_LAST);
    always_comb begin
        in_addr = '0;
        case (in_op)
            tsc_pkg::OP_DATA: begin
                if ((i_data_byte >= tsc_pkg::FIRST_PRINT) &&
                    (i_data_byte <= tsc_pkg::LAST_PRINT)) begin
                    in_addr = byte_off[tsc_pkg::BIN_AW-1:0];
                end
            end
            tsc_pkg::OP_READ: begin
                if (in_bin_ok) begin
                    in_addr = i_bin_index;
                end
            end
            default: begin
                in_addr = '0;
            end
        endcase
    end

    always_comb begin
        hist_ctl.rd      = in_accept;
        hist_ctl.rd_addr = in_addr;
        hist_ctl.inc     = hist_inc;
        hist_ctl.clr     = s1_retire && (r_s1_op == tsc_pkg::OP_CLEAR);
    end

    tsc_counters #(
        .COUNT_BITS (COUNT_BITS)
    ) u_counters (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_retire   (s1_retire),
        .i_op       (r_s1_op),
        .i_byte     (r_s1_byte),
        .o_hist_inc (hist_inc),
        .o_lines    (cnt_lines),
        .o_words    (cnt_words),
        .o_bytes    (cnt_bytes),
        .o_longest  (cnt_longest)
    );

    tsc_hist #(
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hist_ctl),
        .o_count (bin_value)
    );

    // Counters fit into 32-bit fields by zero extension or truncation
    assign ext_lines   = {{tsc_pkg::OUT_W{1'b0}}, cnt_lines};
    assign ext_words   = {{tsc_pkg::OUT_W{1'b0}}, cnt_words};
    assign ext_bytes   = {{tsc_pkg::OUT_W{1'b0}}, cnt_bytes};
    assign ext_longest = {{tsc_pkg::OUT_W{1'b0}}, cnt_longest};
    assign ext_bin     = {{tsc_pkg::OUT_W{1'b0}}, bin_value};

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op     <= in_op;
            r_s1_byte   <= i_data_byte;
            r_s1_bin_ok <= in_bin_ok;
        end
        if (out_load) begin
            if (r_s1_op == tsc_pkg::OP_FINISH) begin
                r_out_kind    <= tsc_pkg::KIND_TOTALS;
                r_out_lines   <= ext_lines[tsc_pkg::OUT_W-1:0];
                r_out_words   <= ext_words[tsc_pkg::OUT_W-1:0];
                r_out_bytes   <= ext_bytes[tsc_pkg::OUT_W-1:0];
                r_out_longest <= ext_longest[tsc_pkg::OUT_W-1:0];
                r_out_bin     <= '0;
            end else begin
                r_out_kind    <= tsc_pkg::KIND_BIN;
                r_out_lines   <= '0;
                r_out_words   <= '0;
                r_out_bytes   <= '0;
                r_out_longest <= '0;
                r_out_bin     <= r_s1_bin_ok ? ext_bin[tsc_pkg::OUT_W-1:0] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_retire) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_line_count   = r_out_lines;
    assign o_word_count   = r_out_words;
    assign o_byte_count   = r_out_bytes;
    assign o_longest_line = r_out_longest;
    assign o_bin_count    = r_out_bin;

endmodule

FILE: verif/text_statistics_counter_tb.sv
// Self-checking testbench for the text statistics counter: random traffic, predictor, scoreboard.
module text_statistics_counter_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 350;
    localparam int HOLD_CYCLES    = 120;
    localparam int PRESSURE_AT    = 30;

    typedef struct {
        tsc_pkg::t_op op;
        logic [7:0]   data;
        logic [6:0]   bin_idx;
    } t_word_in;

    typedef struct {
        logic        kind;
        logic [31:0] lf_cnt;
        logic [31:0] word_cnt;
        logic [31:0] byte_cnt;
        logic [31:0] longest;
        logic [31:0] bin_cnt;
    } t_report;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic [tsc_pkg::OP_W-1:0]     i_op        = tsc_pkg::OP_DATA;
    logic [tsc_pkg::BYTE_W-1:0]   i_data_byte = '0;
    logic [tsc_pkg::BIN_AW-1:0]   i_bin_index = '0;
    logic                         i_stall     = 1'b0;
    logic                         o_stall;
    logic                         o_valid;
    logic                         o_kind;
    logic [tsc_pkg::OUT_W-1:0]    o_line_count;
    logic [tsc_pkg::OUT_W-1:0]    o_word_count;
    logic [tsc_pkg::OUT_W-1:0]    o_byte_count;
    logic [tsc_pkg::OUT_W-1:0]    o_longest_line;
    logic [tsc_pkg::OUT_W-1:0]    o_bin_count;

    text_statistics_counter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_data_byte    (i_data_byte),
        .i_bin_index    (i_bin_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_line_count   (o_line_count),
        .o_word_count   (o_word_count),
        .o_byte_count   (o_byte_count),
        .o_longest_line (o_longest_line),
        .o_bin_count    (o_bin_count)
    );

    always #10 i_clk = ~i_clk;

    t_word_in    pending_words[$];
    t_report     expected_reports[$];
    int          error_count  = 0;
    int          reports_seen = 0;
    int          words_taken  = 0;
    int          idle_cycles  = 0;
    int unsigned cycle_cnt    = 0;
    logic        calm;

    // Predicted block state
    logic [31:0] lf_total, word_total, byte_total, line_len, longest_len;
    logic        in_gap, eot_seen;
    logic [31:0] char_tally [tsc_pkg::BIN_COUNT];

    // Alternate windows with no idling on either side
    assign calm = cycle_cnt[8];

    function automatic logic [31:0] sat_up(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_statistics();
        lf_total    = '0;
        word_total  = '0;
        byte_total  = '0;
        line_len    = '0;
        longest_len = '0;
        in_gap      = 1'b1;
        eot_seen    = 1'b0;
        for (int k = 0; k < tsc_pkg::BIN_COUNT; k++) char_tally[k] = '0;
    endtask

    task automatic predict_statistics(input tsc_pkg::t_op op, input logic [7:0] b,
                                      input logic [6:0] idx);
        t_report    r;
        logic [7:0] bin;
        r = '{kind: tsc_pkg::KIND_TOTALS, lf_cnt: '0, word_cnt: '0, byte_cnt: '0,
              longest: '0, bin_cnt: '0};
        bin = b - tsc_pkg::FIRST_PRINT;
        case (op)
            tsc_pkg::OP_DATA: begin
                if (!eot_seen) begin
                    if (b == tsc_pkg::CH_NUL) begin
                        eot_seen = 1'b1;
                    end else begin
                        byte_total = sat_up(byte_total);
                        if (b == tsc_pkg::CH_LF) begin
                            lf_total = sat_up(lf_total);
                            if (line_len > longest_len) longest_len = line_len;
                            line_len = '0;
                        end else if (b != tsc_pkg::CH_CR) begin
                            line_len = sat_up(line_len);
                        end
                        if (b >= tsc_pkg::FIRST_PRINT && b <= tsc_pkg::LAST_PRINT) begin
                            if (in_gap) word_total = sat_up(word_total);
                            char_tally[bin] = sat_up(char_tally[bin]);
                        end
                        // 127 is neither a word char nor a separator
                        in_gap = (b < tsc_pkg::FIRST_PRINT) || (b >= tsc_pkg::FIRST_HIGH);
                    end
                end
            end
            tsc_pkg::OP_FINISH: begin
                r.lf_cnt   = lf_total;
                r.word_cnt = word_total;
                r.byte_cnt = byte_total;
                r.longest  = (line_len > longest_len) ? line_len : longest_len;
                expected_reports.push_back(r);
            end
            tsc_pkg::OP_READ: begin
                r.kind    = tsc_pkg::KIND_BIN;
                r.bin_cnt = (idx <= tsc_pkg::BIN_LAST) ? char_tally[idx] : '0;
                expected_reports.push_back(r);
            end
            default: clear_statistics();
        endcase
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at report %0d: %s got %0h want %0h", reports_seen, what, got, want);
        error_count++;
    endtask

    task automatic add_word(input tsc_pkg::t_op op, input logic [7:0] b,
                            input logic [6:0] idx);
        pending_words.push_back('{op: op, data: b, bin_idx: idx});
    endtask

    // Unused fields carry random values so their bits toggle too
    task automatic add_byte(input logic [7:0] b);
        add_word(tsc_pkg::OP_DATA, b, 7'($urandom));
    endtask

    task automatic add_read(input logic [6:0] idx);
        add_word(tsc_pkg::OP_READ, 8'($urandom), idx);
    endtask

    function automatic logic [7:0] random_text_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 8'($urandom_range(33, 126));
        if (r < 70) return 8'd32;
        if (r < 78) return tsc_pkg::CH_LF;
        if (r < 82) return tsc_pkg::CH_CR;
        if (r < 86) return 8'd127;
        if (r < 94) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(1, 31));
    endfunction

    // Driver: pops the next word once the current one is taken
    int       send_gap = 0;
    t_word_in next_word;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_statistics(tsc_pkg::t_op'(i_op), i_data_byte, i_bin_index);
                words_taken <= words_taken + 1;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    next_word    = pending_words.pop_front();
                    i_valid     <= 1'b1;
                    i_op        <= next_word.op;
                    i_data_byte <= next_word.data;
                    i_bin_index <= next_word.bin_idx;
                    send_gap    <= calm ? 0 : pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, with one long hold-off to back the block up
    int   stall_left    = 0;
    int   hold_left     = 0;
    logic pressure_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!pressure_done && words_taken >= PRESSURE_AT) begin
            pressure_done <= 1'b1;
            hold_left     <= HOLD_CYCLES - 1;
            i_stall       <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else begin
            stall_left <= calm ? 0 : pick_gap();
            i_stall    <= 1'b0;
        end
    end

    // Monitor / scoreboard
    t_report want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_reports.size() == 0) begin
                flag_mismatch("report with none pending, kind", 32'(o_kind), 32'(0));
            end else begin
                want = expected_reports.pop_front();
                if (o_kind !== want.kind)
                    flag_mismatch("kind", 32'(o_kind), 32'(want.kind));
                if (o_line_count !== want.lf_cnt)
                    flag_mismatch("line_count", o_line_count, want.lf_cnt);
                if (o_word_count !== want.word_cnt)
                    flag_mismatch("word_count", o_word_count, want.word_cnt);
                if (o_byte_count !== want.byte_cnt)
                    flag_mismatch("byte_count", o_byte_count, want.byte_cnt);
                if (o_longest_line !== want.longest)
                    flag_mismatch("longest_line", o_longest_line, want.longest);
                if (o_bin_count !== want.bin_cnt)
                    flag_mismatch("bin_count", o_bin_count, want.bin_cnt);
            end
            reports_seen <= reports_seen + 1;
        end
    end

    // Watchdog: no word moving on either side for too long
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int   counted;
        int   len;
        int   r;
        logic ended;

        clear_statistics();

        // Directed: empty state, word rules, line lengths, bin edges, end of text
        add_word(tsc_pkg::OP_FINISH, 8'hFF, 7'h7F);
        add_read(7'd0);
        add_byte(8'd97);     // word at start of text
        add_byte(8'd127);    // DEL: not a separator
        add_byte(8'd98);     // so no new word here
        add_byte(8'd32);
        add_byte(8'd33);
        add_byte(8'd126);
        add_byte(8'd128);
        add_byte(8'd120);
        add_byte(8'd255);
        add_byte(tsc_pkg::CH_CR);
        add_byte(tsc_pkg::CH_LF);
        add_byte(8'd121);
        add_byte(8'd9);
        add_word(tsc_pkg::OP_FINISH, 8'h00, 7'h00);
        add_read(7'd0);
        add_read(tsc_pkg::BIN_LAST);
        add_read(7'd94);
        add_read(7'd127);
        add_byte(tsc_pkg::CH_NUL);
        add_byte(8'd122);    // past end of text, ignored
        add_word(tsc_pkg::OP_FINISH, 8'h5A, 7'h2A);
        add_word(tsc_pkg::OP_CLEAR, 8'hA5, 7'h55);
        add_word(tsc_pkg::OP_FINISH, 8'h00, 7'h00);
        add_read(tsc_pkg::BIN_LAST);

        // Burst of reads to fill the block during the long hold-off
        for (int k = 0; k < 24; k++) add_read(7'($urandom_range(0, 127)));

        counted = 0;
        while (counted < RANDOM_WORDS) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(3, 30);
            ended = 1'b0;
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    add_read(($urandom_range(0, 4) == 0) ? 7'($urandom_range(94, 127))
                                                         : 7'($urandom_range(0, 93)));
                    counted++;
                end else if (r < 14) begin
                    add_word(tsc_pkg::OP_FINISH, 8'($urandom), 7'($urandom));
                    counted++;
                end else if (r < 16 && !ended) begin
                    add_byte(tsc_pkg::CH_NUL);
                    ended = 1'b1;
                    counted++;
                end else if (r == 16) begin
                    add_word(tsc_pkg::OP_CLEAR, 8'($urandom), 7'($urandom));
                    ended = 1'b0;
                    counted++;
                end else begin
                    add_byte(random_text_byte());
                    counted++;
                end
            end
            add_word(tsc_pkg::OP_FINISH, 8'($urandom), 7'($urandom));
            counted++;
            if ($urandom_range(0, 2) != 0) begin
                add_word(tsc_pkg::OP_CLEAR, 8'($urandom), 7'($urandom));
                counted++;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tsc_pkg.sv
rtl/tsc_hist.sv
rtl/tsc_counters.sv
rtl/text_statistics_counter.sv
verif/text_statistics_counter_tb.sv
